// ===== design/mqsp_pkg.sv =====
// Shared types, constants and reply tables for the MQTT packet responder.
package mqsp_pkg;

   localparam int MAX_PACKET_LEN_DEF = 8192;
   localparam int MAX_TOPIC_LEN_DEF  = 256;

   localparam int RLEN_ACC_W = 28;
   localparam int PREFIX_LEN = 11;
   localparam int IDX_W      = 3;

   localparam logic [3:0] PKT_CONNECT    = 4'd1;
   localparam logic [3:0] PKT_PUBLISH    = 4'd3;
   localparam logic [3:0] PKT_SUBSCRIBE  = 4'd8;
   localparam logic [3:0] PKT_PINGREQ    = 4'd12;
   localparam logic [3:0] PKT_DISCONNECT = 4'd14;

   localparam logic [1:0] QOS_ONE = 2'b01;

   localparam logic [7:0] CONNACK_HDR  = 8'h20;
   localparam logic [7:0] PUBACK_HDR   = 8'h40;
   localparam logic [7:0] SUBACK_HDR   = 8'h90;
   localparam logic [7:0] PINGRESP_HDR = 8'hd0;
   localparam logic [7:0] ACK_LEN_TWO  = 8'h02;
   localparam logic [7:0] ACK_LEN_THREE = 8'h03;
   localparam logic [7:0] ZERO_BYTE    = 8'h00;

   localparam logic [7:0] TOPIC_PREFIX [PREFIX_LEN] = '{
      8'h71, 8'h61, 8'h69, 8'h6f, 8'h74, 8'h2f, 8'h6d, 8'h71, 8'h74, 8'h74, 8'h2f
   };

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_LENGTH,
      PH_BODY
   } phase_type;

   typedef enum logic [2:0] {
      RK_CONNACK,
      RK_PUBACK,
      RK_SUBACK,
      RK_PINGRESP,
      RK_CLOSE
   } reply_kind_type;

   typedef struct packed {
      logic           valid;
      reply_kind_type kind;
      logic [15:0]    ident;
      logic           subscribed;
   } reply_type;

   function automatic logic [IDX_W-1:0] reply_len(input reply_kind_type kind);
      logic [IDX_W-1:0] len;
      unique case (kind)
         RK_CONNACK:  len = IDX_W'(4);
         RK_PUBACK:   len = IDX_W'(4);
         RK_SUBACK:   len = IDX_W'(5);
         RK_PINGRESP: len = IDX_W'(2);
         RK_CLOSE:    len = IDX_W'(1);
         default:     len = IDX_W'(1);
      endcase
      return len;
   endfunction

   function automatic logic [7:0] reply_byte(input reply_kind_type kind,
                                             input logic [IDX_W-1:0] idx,
                                             input logic [15:0] ident);
      logic [7:0] b;
      b = ZERO_BYTE;
      unique case (kind)
         RK_CONNACK: begin
            if (idx == IDX_W'(0)) b = CONNACK_HDR;
            else if (idx == IDX_W'(1)) b = ACK_LEN_TWO;
         end
         RK_PUBACK: begin
            if (idx == IDX_W'(0)) b = PUBACK_HDR;
            else if (idx == IDX_W'(1)) b = ACK_LEN_TWO;
            else if (idx == IDX_W'(2)) b = ident[15:8];
            else if (idx == IDX_W'(3)) b = ident[7:0];
         end
         RK_SUBACK: begin
            if (idx == IDX_W'(0)) b = SUBACK_HDR;
            else if (idx == IDX_W'(1)) b = ACK_LEN_THREE;
            else if (idx == IDX_W'(2)) b = ident[15:8];
            else if (idx == IDX_W'(3)) b = ident[7:0];
         end
         RK_PINGRESP: begin
            if (idx == IDX_W'(0)) b = PINGRESP_HDR;
         end
         RK_CLOSE: b = ZERO_BYTE;
         default:  b = ZERO_BYTE;
      endcase
      return b;
   endfunction

endpackage

// ===== design/mqtt_server_packet_responder_top.sv =====
// Top level of the MQTT server packet responder.
//
//   channel   direction  handshake            payload
//   req       in         req_valid/req_stall  req_func, req_rx_byte
//   rsp       out        rsp_valid/rsp_stall  rsp_tx_byte, rsp_tx_last, rsp_close_conn,
//                                             rsp_is_subscribed
//
// One received byte is taken per cycle while req_stall is low; the parser
// state updates in that cycle. A reply of one to five words leaves the emitter at
// one word per cycle while rsp_stall is low, from the current reply register.
// Reset is synchronous and returns the parser to waiting for a header byte.
// req_stall rises only while a second reply waits in the skid register behind
// the one being sent.
module mqtt_server_packet_responder_top #(
   parameter int MAX_PACKET_LEN = mqsp_pkg::MAX_PACKET_LEN_DEF,
   parameter int MAX_TOPIC_LEN  = mqsp_pkg::MAX_TOPIC_LEN_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_func,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_tx_byte,
   output logic       rsp_tx_last,
   output logic       rsp_close_conn,
   output logic       rsp_is_subscribed
);

   mqsp_pkg::reply_type reply;
   logic busy;

   assign req_stall = busy;

   mqsp_parser #(
      .MAX_PACKET_LEN(MAX_PACKET_LEN),
      .MAX_TOPIC_LEN (MAX_TOPIC_LEN)
   ) u_parser (
      .clock  (clock),
      .reset  (reset),
      .accept (req_valid && !busy),
      .func   (req_func),
      .rx_byte(req_rx_byte),
      .reply  (reply)
   );

   mqsp_emitter u_emitter (
      .clock            (clock),
      .reset            (reset),
      .reply            (reply),
      .busy             (busy),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_tx_byte      (rsp_tx_byte),
      .rsp_tx_last      (rsp_tx_last),
      .rsp_close_conn   (rsp_close_conn),
      .rsp_is_subscribed(rsp_is_subscribed)
   );

endmodule

// ===== design/mqsp_parser.sv =====
// Per-byte packet parser: header, remaining length, body capture and reply choice.
module mqsp_parser #(
   parameter int MAX_PACKET_LEN = mqsp_pkg::MAX_PACKET_LEN_DEF,
   parameter int MAX_TOPIC_LEN  = mqsp_pkg::MAX_TOPIC_LEN_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic                func,
   input  logic [7:0]          rx_byte,
   output mqsp_pkg::reply_type reply
);

   localparam int LEN_W = $clog2(MAX_PACKET_LEN + 1);
   localparam int CMP_W = (LEN_W > 17) ? LEN_W : 17;
   localparam int ACC_W = mqsp_pkg::RLEN_ACC_W;

   mqsp_pkg::phase_type phase_ff, phase_in;
   logic [7:0]       header_ff, header_in;
   logic [ACC_W-1:0] rlen_ff, rlen_in;
   logic [1:0]       digits_ff, digits_in;
   logic [LEN_W-1:0] bidx_ff, bidx_in;
   logic [15:0]      tlen_ff, tlen_in;
   logic [15:0]      ident_ff, ident_in;
   logic             pmatch_ff, pmatch_in;
   logic             sub_ff, sub_in;
   logic             closed_ff, closed_in;

   logic [ACC_W-1:0] digit;
   logic [LEN_W-1:0] n;
   logic [CMP_W-1:0] k_w, n_w, tl_w;
   logic [3:0]       pidx;
   logic             do_finish, do_close;

   always_comb begin
      phase_in  = phase_ff;
      header_in = header_ff;
      rlen_in   = rlen_ff;
      digits_in = digits_ff;
      bidx_in   = bidx_ff;
      tlen_in   = tlen_ff;
      ident_in  = ident_ff;
      pmatch_in = pmatch_ff;
      sub_in    = sub_ff;
      closed_in = closed_ff;
      do_finish = 1'b0;
      do_close  = 1'b0;
      reply     = '{valid: 1'b0, kind: mqsp_pkg::RK_CLOSE, ident: ident_ff, subscribed: 1'b0};

      unique case (digits_ff)
         2'd0: digit = ACC_W'(rx_byte[6:0]);
         2'd1: digit = ACC_W'(rx_byte[6:0]) << 7;
         2'd2: digit = ACC_W'(rx_byte[6:0]) << 14;
         2'd3: digit = ACC_W'(rx_byte[6:0]) << 21;
         default: digit = '0;
      endcase

      k_w  = CMP_W'(bidx_ff);
      pidx = 4'(bidx_ff - LEN_W'(4));

      if (accept) begin
         if (func) begin
            phase_in  = mqsp_pkg::PH_HEADER;
            header_in = '0;
            rlen_in   = '0;
            digits_in = '0;
            bidx_in   = '0;
            tlen_in   = '0;
            ident_in  = '0;
            pmatch_in = 1'b1;
            sub_in    = 1'b0;
            closed_in = 1'b0;
         end else if (!closed_ff) begin
            unique case (phase_ff)
               mqsp_pkg::PH_HEADER: begin
                  header_in = rx_byte;
                  rlen_in   = '0;
                  digits_in = '0;
                  bidx_in   = '0;
                  tlen_in   = '0;
                  ident_in  = '0;
                  pmatch_in = 1'b1;
                  phase_in  = mqsp_pkg::PH_LENGTH;
               end
               mqsp_pkg::PH_LENGTH: begin
                  rlen_in = rlen_ff | digit;
                  if (rx_byte[7]) begin
                     if (digits_ff == 2'd3) do_close = 1'b1;
                     else digits_in = digits_ff + 2'd1;
                  end else if (rlen_in > ACC_W'(MAX_PACKET_LEN)) begin
                     do_close = 1'b1;
                  end else if (rlen_in == '0) begin
                     do_finish = 1'b1;
                  end else begin
                     phase_in = mqsp_pkg::PH_BODY;
                  end
               end
               mqsp_pkg::PH_BODY: begin
                  tl_w = CMP_W'(tlen_ff);
                  if (header_ff[7:4] == mqsp_pkg::PKT_PUBLISH) begin
                     if (bidx_ff == LEN_W'(0)) tlen_in[15:8] = rx_byte;
                     else if (bidx_ff == LEN_W'(1)) tlen_in[7:0] = rx_byte;
                     else if (k_w == tl_w + CMP_W'(2)) ident_in[15:8] = rx_byte;
                     else if (k_w == tl_w + CMP_W'(3)) ident_in[7:0] = rx_byte;
                  end else if (header_ff[7:4] == mqsp_pkg::PKT_SUBSCRIBE) begin
                     if (bidx_ff == LEN_W'(0)) ident_in[15:8] = rx_byte;
                     else if (bidx_ff == LEN_W'(1)) ident_in[7:0] = rx_byte;
                     else if (bidx_ff == LEN_W'(2)) tlen_in[15:8] = rx_byte;
                     else if (bidx_ff == LEN_W'(3)) tlen_in[7:0] = rx_byte;
                     else if (k_w >= CMP_W'(4) &&
                              k_w < CMP_W'(4 + mqsp_pkg::PREFIX_LEN)) begin
                        if (rx_byte != mqsp_pkg::TOPIC_PREFIX[pidx]) pmatch_in = 1'b0;
                     end
                  end
                  bidx_in = bidx_ff + LEN_W'(1);
                  if (bidx_in >= rlen_ff[LEN_W-1:0]) do_finish = 1'b1;
               end
               default: phase_in = mqsp_pkg::PH_HEADER;
            endcase
         end
      end

      n    = rlen_in[LEN_W-1:0];
      n_w  = CMP_W'(n);
      tl_w = CMP_W'(tlen_in);

      if (do_finish) begin
         phase_in = mqsp_pkg::PH_HEADER;
         priority case (header_ff[7:4])
            mqsp_pkg::PKT_CONNECT: begin
               reply.valid = 1'b1;
               reply.kind  = mqsp_pkg::RK_CONNACK;
            end
            mqsp_pkg::PKT_PUBLISH: begin
               if (header_ff[2:1] == mqsp_pkg::QOS_ONE && n >= LEN_W'(4) &&
                   tl_w + CMP_W'(4) <= n_w) begin
                  reply.valid = 1'b1;
                  reply.kind  = mqsp_pkg::RK_PUBACK;
               end
            end
            mqsp_pkg::PKT_SUBSCRIBE: begin
               if (n < LEN_W'(5) || tlen_in == 16'd0 ||
                   17'(tlen_in) >= 17'(MAX_TOPIC_LEN) ||
                   tl_w + CMP_W'(5) > n_w ||
                   tlen_in < 16'(mqsp_pkg::PREFIX_LEN) || !pmatch_in) begin
                  do_close = 1'b1;
               end else begin
                  sub_in      = 1'b1;
                  reply.valid = 1'b1;
                  reply.kind  = mqsp_pkg::RK_SUBACK;
               end
            end
            mqsp_pkg::PKT_PINGREQ: begin
               reply.valid = 1'b1;
               reply.kind  = mqsp_pkg::RK_PINGRESP;
            end
            mqsp_pkg::PKT_DISCONNECT: do_close = 1'b1;
            default: reply.valid = 1'b0;
         endcase
      end

      if (do_close) begin
         closed_in   = 1'b1;
         sub_in      = 1'b0;
         phase_in    = mqsp_pkg::PH_HEADER;
         reply.valid = 1'b1;
         reply.kind  = mqsp_pkg::RK_CLOSE;
      end

      reply.ident      = ident_in;
      reply.subscribed = sub_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= mqsp_pkg::PH_HEADER;
         header_ff <= '0;
         rlen_ff   <= '0;
         digits_ff <= '0;
         bidx_ff   <= '0;
         tlen_ff   <= '0;
         ident_ff  <= '0;
         pmatch_ff <= 1'b1;
         sub_ff    <= 1'b0;
         closed_ff <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         header_ff <= header_in;
         rlen_ff   <= rlen_in;
         digits_ff <= digits_in;
         bidx_ff   <= bidx_in;
         tlen_ff   <= tlen_in;
         ident_ff  <= ident_in;
         pmatch_ff <= pmatch_in;
         sub_ff    <= sub_in;
         closed_ff <= closed_in;
      end
   end

endmodule

// ===== design/mqsp_emitter.sv =====
// Reply serialiser: current reply register, skid register and per-word byte index.
module mqsp_emitter (
   input  logic                clock,
   input  logic                reset,
   input  mqsp_pkg::reply_type reply,
   output logic                busy,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [7:0]          rsp_tx_byte,
   output logic                rsp_tx_last,
   output logic                rsp_close_conn,
   output logic                rsp_is_subscribed
);

   mqsp_pkg::reply_type cur_ff, cur_in;
   mqsp_pkg::reply_type hold_ff, hold_in;
   logic [mqsp_pkg::IDX_W-1:0] idx_ff, idx_in;
   logic last, sent, free;

   assign last = idx_ff == mqsp_pkg::reply_len(cur_ff.kind) - mqsp_pkg::IDX_W'(1);
   assign sent = cur_ff.valid && !rsp_stall;
   assign free = !cur_ff.valid || (sent && last);

   always_comb begin
      cur_in  = cur_ff;
      hold_in = hold_ff;
      idx_in  = idx_ff;
      if (free) begin
         idx_in = '0;
         if (hold_ff.valid) begin
            cur_in        = hold_ff;
            hold_in.valid = 1'b0;
         end else begin
            cur_in = reply;
         end
      end else begin
         if (sent) idx_in = idx_ff + mqsp_pkg::IDX_W'(1);
         if (reply.valid) hold_in = reply;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff  <= '0;
         hold_ff <= '0;
         idx_ff  <= '0;
      end else begin
         cur_ff  <= cur_in;
         hold_ff <= hold_in;
         idx_ff  <= idx_in;
      end
   end

   assign busy              = hold_ff.valid;
   assign rsp_valid         = cur_ff.valid;
   assign rsp_tx_byte       = mqsp_pkg::reply_byte(cur_ff.kind, idx_ff, cur_ff.ident);
   assign rsp_tx_last       = last;
   assign rsp_close_conn    = cur_ff.kind == mqsp_pkg::RK_CLOSE;
   assign rsp_is_subscribed = cur_ff.subscribed;

endmodule
